[hw/rtl/assert_macros.svh]
// Assertion macros shared by the modular arithmetic unit RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("assertion failed: never condition seen");

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication broken");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication broken");

`endif

[hw/rtl/mau_pkg.sv]
// Package for the modular arithmetic unit: word types, opcodes, FSM states,
// controller/datapath command and status structs. No dependencies.
package mau_pkg;

	localparam int OPERAND_BITS       = 31;
	localparam int EXP_BITS           = 63;
	localparam int RAW_BITS           = 64;
	localparam int MOD_BITS           = 32;
	localparam int CNT_BITS           = 7;
	localparam int VALUE_BITS_DEFAULT = 31;
	localparam logic [MOD_BITS-1:0] MOD_RESET = 32'd998244353;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_POW    = 3'd4,
		OP_INV    = 3'd5,
		OP_NEG    = 3'd6,
		OP_REDUCE = 3'd7
	} op_t;

	typedef struct packed {
		op_t                       cmd;
		logic [OPERAND_BITS-1:0]   operand_a;
		logic [OPERAND_BITS-1:0]   operand_b;
		logic [EXP_BITS-1:0]       exponent;
		logic signed [RAW_BITS-1:0] raw_value;
	} op_word_t;

	typedef struct packed {
		logic [OPERAND_BITS-1:0] result;
		logic                    bad_operand;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POW_TEST,
		ST_POW_WAIT,
		ST_MUL_WAIT,
		ST_FINISH
	} state_t;

	// operand routing for the main modular multiplier
	typedef enum logic [1:0] {
		MM_MUL,
		MM_DIV_FIN,
		MM_REDUCE,
		MM_POW
	} mm_sel_t;

	typedef enum logic [1:0] {
		RES_SIMPLE,
		RES_PROD,
		RES_POW
	} res_sel_t;

	typedef struct packed {
		logic     ready;
		logic     load;
		logic     pow_init;
		logic     mm_start;
		mm_sel_t  mm_sel;
		logic     step_take;
		logic     res_we;
		res_sel_t res_sel;
		logic     out_load;
	} ctl_t;

	typedef struct packed {
		op_t  cmd;
		logic bad;
		logic n_zero;
		logic mm_done;
		logic step_done;
		logic out_free;
	} status_t;

endpackage

[hw/rtl/mau_modmul.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Depends on mau_pkg.
module mau_modmul #(
	parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [VALUE_BITS-1:0]           a,
	input  logic [mau_pkg::RAW_BITS-1:0]    b,
	input  logic [mau_pkg::CNT_BITS-1:0]    nbits,
	input  logic [VALUE_BITS:0]             m,
	output logic                            done,
	output logic [VALUE_BITS-1:0]           p
);

	localparam int RawBits = mau_pkg::RAW_BITS;
	localparam int CntBits = mau_pkg::CNT_BITS;

	logic                    busy_q;
	logic                    done_q;
	logic [CntBits-1:0]      cnt_q;
	logic [VALUE_BITS-1:0]   a_q;
	logic [VALUE_BITS-1:0]   r_q;
	logic [RawBits-1:0]      b_q;
	logic [VALUE_BITS+1:0]   t;
	logic [VALUE_BITS+1:0]   m1;
	logic [VALUE_BITS+1:0]   m2;
	logic [VALUE_BITS+1:0]   r_next;

	// r < m and a < m (or a = 1) keep t below 3m
	assign t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[RawBits-1] ? a_q : '0)};
	assign m1 = {1'b0, m};
	assign m2 = {m, 1'b0};
	assign r_next = (t >= m2) ? (t - m2) : ((t >= m1) ? (t - m1) : t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntBits'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntBits'(1);
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q << 1;
			r_q <= r_next[VALUE_BITS-1:0];
		end
	end

	assign done = done_q;
	assign p    = r_q;

endmodule

[hw/rtl/mau_datapath.sv]
// Datapath: modulus register, operand registers, simple ops, two modular
// multipliers, result and output registers. Depends on mau_pkg, mau_modmul.
module mau_datapath #(
	parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mau_pkg::ctl_t                 ctl,
	output mau_pkg::status_t              status,
	input  mau_pkg::op_word_t             op_word,
	input  logic                          cfg_we,
	input  logic [mau_pkg::MOD_BITS-1:0]  cfg_data,
	input  logic                          res_stall,
	output logic                          res_valid,
	output mau_pkg::res_word_t            res_word
);

	localparam int W       = VALUE_BITS;
	localparam int ModBits = mau_pkg::MOD_BITS;
	localparam int OpBits  = mau_pkg::OPERAND_BITS;
	localparam int ExpBits = mau_pkg::EXP_BITS;
	localparam int RawBits = mau_pkg::RAW_BITS;
	localparam int CntBits = mau_pkg::CNT_BITS;
	localparam int PadBits = RawBits - W;
	localparam logic [ModBits-1:0] ModLimit = ModBits'(1) << W;

	logic [ModBits-1:0]  mod_q;
	logic [ModBits-1:0]  m_eff;
	logic                a_ge;
	logic                b_ge;
	logic                bad_in;
	logic [RawBits-1:0]  raw_u;
	logic [RawBits-1:0]  mag;

	mau_pkg::op_t        cmd_q;
	logic                bad_q;
	logic                neg_q;
	logic [W:0]          m_q;
	logic [OpBits-1:0]   a_q;
	logic [OpBits-1:0]   b_q;
	logic [ExpBits-1:0]  n_q;
	logic [RawBits-1:0]  mag_q;
	logic [W-1:0]        r_q;
	logic [W-1:0]        x_q;
	logic [W-1:0]        res_q;
	logic                res_valid_q;
	mau_pkg::res_word_t  res_word_q;

	logic [W-1:0]        a_w;
	logic [W-1:0]        b_w;
	logic [W:0]          sum_ab;
	logic [W:0]          add_v;
	logic [W:0]          sub_v;
	logic [W:0]          neg_v;
	logic [W:0]          red_v;
	logic [W:0]          fermat;
	logic [W-1:0]        simple_v;

	logic [W-1:0]        mm0_a;
	logic [RawBits-1:0]  mm0_b;
	logic [CntBits-1:0]  mm0_n;
	logic                mm0_done;
	logic [W-1:0]        mm0_p;
	logic                mm1_start;
	logic                mm1_done;
	logic [W-1:0]        mm1_p;

	// effective modulus and operand check at accept
	assign m_eff = (mod_q > ModLimit) ? ModLimit : mod_q;
	assign a_ge  = {1'b0, op_word.operand_a} >= m_eff;
	assign b_ge  = {1'b0, op_word.operand_b} >= m_eff;
	assign raw_u = op_word.raw_value;
	assign mag   = raw_u[RawBits-1] ? (~raw_u + RawBits'(1)) : raw_u;

	always_comb begin
		unique case (op_word.cmd)
			mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_MUL, mau_pkg::OP_DIV:
				bad_in = a_ge || b_ge;
			mau_pkg::OP_POW, mau_pkg::OP_INV, mau_pkg::OP_NEG:
				bad_in = a_ge;
			default:
				bad_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= mau_pkg::MOD_RESET;
		end else if (cfg_we) begin
			mod_q <= cfg_data;
		end
	end

	assign a_w = a_q[W-1:0];
	assign b_w = b_q[W-1:0];

	assign sum_ab = {1'b0, a_w} + {1'b0, b_w};
	assign add_v  = (sum_ab >= m_q) ? (sum_ab - m_q) : sum_ab;
	assign sub_v  = (a_w >= b_w) ? ({1'b0, a_w} - {1'b0, b_w})
		: ({1'b0, a_w} + m_q - {1'b0, b_w});
	assign neg_v  = (a_w == '0) ? '0 : (m_q - {1'b0, a_w});
	assign red_v  = (mm0_p == '0) ? '0 : (m_q - {1'b0, mm0_p});
	assign fermat = (m_q >= (W+1)'(2)) ? (m_q - (W+1)'(2)) : '0;

	always_comb begin
		unique case (cmd_q)
			mau_pkg::OP_ADD: simple_v = add_v[W-1:0];
			mau_pkg::OP_SUB: simple_v = sub_v[W-1:0];
			mau_pkg::OP_NEG: simple_v = neg_v[W-1:0];
			default:         simple_v = '0;
		endcase
	end

	always_comb begin
		unique case (ctl.mm_sel)
			mau_pkg::MM_MUL: begin
				mm0_a = a_w;
				mm0_b = {b_w, {PadBits{1'b0}}};
				mm0_n = CntBits'(W);
			end
			mau_pkg::MM_DIV_FIN: begin
				mm0_a = a_w;
				mm0_b = {r_q, {PadBits{1'b0}}};
				mm0_n = CntBits'(W);
			end
			mau_pkg::MM_REDUCE: begin
				mm0_a = W'(1);
				mm0_b = mag_q;
				mm0_n = CntBits'(RawBits);
			end
			default: begin
				mm0_a = r_q;
				mm0_b = {x_q, {PadBits{1'b0}}};
				mm0_n = CntBits'(W);
			end
		endcase
	end

	assign mm1_start = ctl.mm_start && (ctl.mm_sel == mau_pkg::MM_POW);

	mau_modmul #(.VALUE_BITS(W)) u_mm0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mm_start),
		.a      (mm0_a),
		.b      (mm0_b),
		.nbits  (mm0_n),
		.m      (m_q),
		.done   (mm0_done),
		.p      (mm0_p)
	);

	mau_modmul #(.VALUE_BITS(W)) u_mm1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm1_start),
		.a      (x_q),
		.b      ({x_q, {PadBits{1'b0}}}),
		.nbits  (CntBits'(W)),
		.m      (m_q),
		.done   (mm1_done),
		.p      (mm1_p)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= op_word.cmd;
			bad_q <= bad_in || (m_eff == '0);
			neg_q <= raw_u[RawBits-1] && (op_word.cmd == mau_pkg::OP_REDUCE);
			m_q   <= m_eff[W:0];
			a_q   <= op_word.operand_a;
			b_q   <= op_word.operand_b;
			n_q   <= op_word.exponent;
			mag_q <= mag;
		end
		if (ctl.pow_init) begin
			x_q <= (cmd_q == mau_pkg::OP_DIV) ? b_w : a_w;
			r_q <= (m_q == (W+1)'(1)) ? '0 : W'(1);
			if (cmd_q != mau_pkg::OP_POW) begin
				n_q <= ExpBits'(fermat);
			end
		end else if (ctl.step_take) begin
			if (n_q[0]) begin
				r_q <= mm0_p;
			end
			x_q <= mm1_p;
			n_q <= n_q >> 1;
		end
		if (ctl.res_we) begin
			unique case (ctl.res_sel)
				mau_pkg::RES_SIMPLE: res_q <= bad_q ? '0 : simple_v;
				mau_pkg::RES_PROD:   res_q <= neg_q ? red_v[W-1:0] : mm0_p;
				mau_pkg::RES_POW:    res_q <= r_q;
				default:             res_q <= '0;
			endcase
		end
		if (ctl.out_load) begin
			res_word_q.result      <= OpBits'(res_q);
			res_word_q.bad_operand <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign status.cmd       = cmd_q;
	assign status.bad       = bad_q;
	assign status.n_zero    = (n_q == '0);
	assign status.mm_done   = mm0_done;
	assign status.step_done = mm0_done && mm1_done;
	assign status.out_free  = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

[hw/rtl/mau_controller.sv]
// Controller FSM: sequences load, simple ops, square-and-multiply rounds
// and the output handoff. Depends on mau_pkg.
module mau_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  mau_pkg::status_t  status,
	output mau_pkg::ctl_t     ctl
);

	mau_pkg::state_t state_q;
	mau_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mau_pkg::ST_IDLE: begin
				if (op_valid) begin
					state_d = mau_pkg::ST_DECODE;
				end
			end
			mau_pkg::ST_DECODE: begin
				if (status.bad) begin
					state_d = mau_pkg::ST_FINISH;
				end else begin
					unique case (status.cmd)
						mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_NEG:
							state_d = mau_pkg::ST_FINISH;
						mau_pkg::OP_MUL, mau_pkg::OP_REDUCE:
							state_d = mau_pkg::ST_MUL_WAIT;
						default:
							state_d = mau_pkg::ST_POW_TEST;
					endcase
				end
			end
			mau_pkg::ST_POW_TEST: begin
				if (!status.n_zero) begin
					state_d = mau_pkg::ST_POW_WAIT;
				end else if (status.cmd == mau_pkg::OP_DIV) begin
					state_d = mau_pkg::ST_MUL_WAIT;
				end else begin
					state_d = mau_pkg::ST_FINISH;
				end
			end
			mau_pkg::ST_POW_WAIT: begin
				if (status.step_done) begin
					state_d = mau_pkg::ST_POW_TEST;
				end
			end
			mau_pkg::ST_MUL_WAIT: begin
				if (status.mm_done) begin
					state_d = mau_pkg::ST_FINISH;
				end
			end
			mau_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_d = mau_pkg::ST_IDLE;
				end
			end
			default: state_d = mau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mm_sel  = mau_pkg::MM_MUL;
		ctl.res_sel = mau_pkg::RES_SIMPLE;
		unique case (state_q)
			mau_pkg::ST_IDLE: begin
				ctl.ready = 1'b1;
				ctl.load  = op_valid;
			end
			mau_pkg::ST_DECODE: begin
				if (status.bad) begin
					ctl.res_we = 1'b1;
				end else begin
					unique case (status.cmd)
						mau_pkg::OP_ADD, mau_pkg::OP_SUB, mau_pkg::OP_NEG:
							ctl.res_we = 1'b1;
						mau_pkg::OP_MUL:
							ctl.mm_start = 1'b1;
						mau_pkg::OP_REDUCE: begin
							ctl.mm_start = 1'b1;
							ctl.mm_sel   = mau_pkg::MM_REDUCE;
						end
						default:
							ctl.pow_init = 1'b1;
					endcase
				end
			end
			mau_pkg::ST_POW_TEST: begin
				if (!status.n_zero) begin
					ctl.mm_start = 1'b1;
					ctl.mm_sel   = mau_pkg::MM_POW;
				end else if (status.cmd == mau_pkg::OP_DIV) begin
					ctl.mm_start = 1'b1;
					ctl.mm_sel   = mau_pkg::MM_DIV_FIN;
				end else begin
					ctl.res_we  = 1'b1;
					ctl.res_sel = mau_pkg::RES_POW;
				end
			end
			mau_pkg::ST_POW_WAIT: begin
				ctl.step_take = status.step_done;
			end
			mau_pkg::ST_MUL_WAIT: begin
				ctl.res_we  = status.mm_done;
				ctl.res_sel = mau_pkg::RES_PROD;
			end
			mau_pkg::ST_FINISH: begin
				ctl.out_load = status.out_free;
			end
			default: ctl = '0;
		endcase
	end

endmodule

[hw/rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit: controller plus datapath.
// Depends on mau_pkg, mau_controller, mau_datapath, assert_macros.svh.
//
//   port group  | dir | handshake            | payload
//   op_*        | in  | op_valid / op_stall  | op_word (mau_pkg::op_word_t)
//   res_*       | out | res_valid / res_stall| res_word (mau_pkg::res_word_t)
//   cfg_*       | in  | cfg_we               | cfg_data (modulus)
//
// One word at a time. Add, sub, negate and bad operands need no multiplier
// pass before the output register; mul and reduce take one pass of the serial
// multiplier (one bit per cycle). Pow/inverse run one square-and-multiply round per
// exponent bit up to the top set bit (63 max for pow, VALUE_BITS for inverse); divide adds one multiply.
// Reset restores modulus 998244353. A waiting result holds only the handoff
// step; the next word is taken while the previous result is still stalled.
`include "assert_macros.svh"

module modular_arithmetic_unit #(
	parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	output logic                          op_stall,
	input  mau_pkg::op_word_t             op_word,
	output logic                          res_valid,
	input  logic                          res_stall,
	output mau_pkg::res_word_t            res_word,
	input  logic                          cfg_we,
	input  logic [mau_pkg::MOD_BITS-1:0]  cfg_data
);

	mau_pkg::ctl_t    ctl;
	mau_pkg::status_t status;

	mau_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.status   (status),
		.ctl      (ctl)
	);

	mau_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.status    (status),
		.op_word   (op_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_word  (res_word)
	);

	assign op_stall = !ctl.ready;

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, op_valid && !op_stall, op_stall)
	`ASSERT_IMPLIES(a_bad_gives_zero, clk, arst_n, res_valid && res_word.bad_operand, res_word.result == '0)
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, ctl.out_load && res_valid && res_stall)

endmodule
